// File: sv/s128pg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 128K paging and ULA port decoder.
// No dependencies; every other file uses this package.
package s128pg_pkg;

    localparam int PAGE_SIZE = 16384;
    localparam int PAGE_BITS = $clog2(PAGE_SIZE);
    localparam int BANK_BITS = 3;
    localparam int MADDR_BITS = BANK_BITS + PAGE_BITS;
    localparam int KBD_ROWS = 8;
    localparam int KBD_COLS = 5;

    // Configuration register indexes
    localparam logic [0:0] CFG_HAS_PAGING = 1'b0;
    localparam logic [0:0] CFG_HAS_SOUND_CHIP = 1'b1;

    // Port decode masks and matches
    localparam logic [15:0] AY_MASK = 16'hC002;
    localparam logic [15:0] AY_SELECT_PORT = 16'hC000;
    localparam logic [15:0] AY_DATA_PORT = 16'h8000;
    localparam logic [15:0] PAGING_MASK = 16'h8002;
    localparam logic [7:0] JOYSTICK_PORT = 8'h1F;
    localparam logic [7:0] KBD_KEEP_MASK = 8'hBF;

    localparam logic [1:0] PAGE_ROM = 2'd0;
    localparam logic [1:0] PAGE_RAM5 = 2'd1;
    localparam logic [1:0] PAGE_RAM2 = 2'd2;
    localparam logic [1:0] PAGE_PAGED = 2'd3;

    localparam logic [BANK_BITS-1:0] BANK_FIVE = 3'd5;
    localparam logic [BANK_BITS-1:0] BANK_TWO = 3'd2;

    typedef enum logic [1:0] {
        REQ_MEM_READ  = 2'd0,
        REQ_MEM_WRITE = 2'd1,
        REQ_IO_READ   = 2'd2,
        REQ_IO_WRITE  = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_ROM  = 2'd1,
        TGT_RAM  = 2'd2
    } mem_target_t;

    typedef enum logic [1:0] {
        SND_NONE   = 2'd0,
        SND_SELECT = 2'd1,
        SND_WRITE  = 2'd2,
        SND_READ   = 2'd3
    } sound_action_t;

    typedef struct packed {
        req_type_t   req_type;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  floating_bus;
        logic [7:0]  sound_read_data;
        logic [KBD_ROWS*KBD_COLS-1:0] keyboard_rows;
        logic        tape_bit;
    } req_item_t;

    typedef struct packed {
        mem_target_t     mem_target;
        logic [MADDR_BITS-1:0] mem_address;
        logic            mem_write;
        logic            contended;
        logic [7:0]      io_read_data;
        logic [2:0]      border_colour;
        logic            ear_out;
        logic            mic_out;
        logic            screen_bank;
        sound_action_t   sound_action;
        logic [7:0]      sound_byte;
    } rsp_item_t;

    typedef struct packed {
        logic                 rom_bank;
        logic [BANK_BITS-1:0] ram_bank;
        logic                 screen_select;
        logic                 paging_locked;
        logic [2:0]           border_latch;
        logic                 ear_latch;
        logic                 mic_latch;
    } ula_state_t;

    typedef struct packed {
        logic has_paging;
        logic has_sound_chip;
    } cfg_t;

endpackage

// File: sv/s128pg_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for bus access requests and results.
// Depends on s128pg_pkg for the payload types.
interface s128pg_req_if;
    logic                  valid;
    logic                  ready;
    s128pg_pkg::req_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface s128pg_rsp_if;
    logic                  valid;
    logic                  ready;
    s128pg_pkg::rsp_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: sv/s128pg_decode.sv
`timescale 1ns / 1ps
// Combinational decode of one bus access: memory map, port decode, latch update.
// Depends on s128pg_pkg.
module s128pg_decode (
    input  s128pg_pkg::req_item_t  item,
    input  s128pg_pkg::ula_state_t state,
    input  s128pg_pkg::cfg_t       cfg,
    output s128pg_pkg::rsp_item_t  result,
    output s128pg_pkg::ula_state_t state_next
);

    function automatic s128pg_pkg::ula_state_t paging_write(
        input s128pg_pkg::ula_state_t s,
        input logic [7:0]             v
    );
        s128pg_pkg::ula_state_t n;
        n = s;
        n.paging_locked = s.paging_locked | v[5];
        n.rom_bank = v[4];
        n.screen_select = v[3];
        n.ram_bank = v[2:0];
        return n;
    endfunction

    logic [1:0]                        page;
    logic [s128pg_pkg::PAGE_BITS-1:0]  offset;
    logic                              page_cont;
    logic                              ay_select_hit;
    logic                              ay_data_hit;
    logic                              paging_hit;
    logic [7:0]                        kbd;
    logic [s128pg_pkg::BANK_BITS-1:0]  bank;
    s128pg_pkg::ula_state_t            st;

    assign page = item.address[15:14];
    assign offset = item.address[s128pg_pkg::PAGE_BITS-1:0];
    assign page_cont = (page == s128pg_pkg::PAGE_RAM5)
                    || (page == s128pg_pkg::PAGE_PAGED && state.ram_bank[0]);
    assign ay_select_hit = ((item.address & s128pg_pkg::AY_MASK) == s128pg_pkg::AY_SELECT_PORT)
                        && cfg.has_sound_chip;
    assign ay_data_hit = ((item.address & s128pg_pkg::AY_MASK) == s128pg_pkg::AY_DATA_PORT)
                      && cfg.has_sound_chip;
    assign paging_hit = (item.address & s128pg_pkg::PAGING_MASK) == 16'h0000;

    // Keyboard matrix: AND every half-row whose select line (A8+i) is low, unless A7..A1 are all zero
    always_comb
    begin
        kbd = 8'hFF;
        if (item.address[7:1] != 7'd0)
        begin
            for (int i = 0; i < s128pg_pkg::KBD_ROWS; i++)
            begin
                if (!item.address[8+i])
                    kbd = kbd & {3'b111, item.keyboard_rows[s128pg_pkg::KBD_COLS*i +:
                                                             s128pg_pkg::KBD_COLS]};
            end
        end
    end

    always_comb
    begin
        st = state;
        bank = '0;
        result = '0;
        result.mem_target = s128pg_pkg::TGT_NONE;
        result.sound_action = s128pg_pkg::SND_NONE;

        unique case (item.req_type) inside
            s128pg_pkg::REQ_MEM_READ, s128pg_pkg::REQ_MEM_WRITE:
            begin
                unique case (page)
                    s128pg_pkg::PAGE_ROM:
                    begin
                        result.mem_target = s128pg_pkg::TGT_ROM;
                        bank = {{(s128pg_pkg::BANK_BITS-1){1'b0}}, state.rom_bank};
                    end
                    s128pg_pkg::PAGE_RAM5:
                    begin
                        result.mem_target = s128pg_pkg::TGT_RAM;
                        bank = s128pg_pkg::BANK_FIVE;
                    end
                    s128pg_pkg::PAGE_RAM2:
                    begin
                        result.mem_target = s128pg_pkg::TGT_RAM;
                        bank = s128pg_pkg::BANK_TWO;
                    end
                    default:
                    begin
                        result.mem_target = s128pg_pkg::TGT_RAM;
                        bank = state.ram_bank;
                    end
                endcase
                result.contended = page_cont;
                result.mem_address = {bank, offset};
                if (item.req_type == s128pg_pkg::REQ_MEM_WRITE)
                begin
                    if (page == s128pg_pkg::PAGE_ROM)
                    begin
                        // ROM write is dropped entirely
                        result.mem_target = s128pg_pkg::TGT_NONE;
                        result.mem_address = '0;
                    end
                    else
                    begin
                        result.mem_write = 1'b1;
                    end
                end
            end
            s128pg_pkg::REQ_IO_READ:
            begin
                result.contended = cfg.has_paging && page_cont;
                if (item.address[0])
                begin
                    if (item.address[7:0] == s128pg_pkg::JOYSTICK_PORT)
                    begin
                        result.io_read_data = 8'h00;
                    end
                    else if (ay_select_hit)
                    begin
                        result.io_read_data = item.sound_read_data;
                        result.sound_action = s128pg_pkg::SND_READ;
                    end
                    else
                    begin
                        // read of the paging port latches the floating bus, lock or not
                        if (paging_hit)
                            st = paging_write(state, item.floating_bus);
                        result.io_read_data = item.floating_bus;
                    end
                end
                else
                begin
                    result.io_read_data = (kbd & s128pg_pkg::KBD_KEEP_MASK)
                                        | {1'b0, state.ear_latch | item.tape_bit, 6'd0};
                end
            end
            s128pg_pkg::REQ_IO_WRITE:
            begin
                result.contended = cfg.has_paging && page_cont;
                if (!item.address[0])
                begin
                    st.ear_latch = item.write_data[4];
                    st.mic_latch = item.write_data[3];
                    st.border_latch = item.write_data[2:0];
                end
                if (ay_select_hit)
                begin
                    result.sound_action = s128pg_pkg::SND_SELECT;
                    result.sound_byte = item.write_data;
                end
                if (ay_data_hit)
                begin
                    result.sound_action = s128pg_pkg::SND_WRITE;
                    result.sound_byte = item.write_data;
                end
                if (paging_hit && !state.paging_locked)
                    st = paging_write(st, item.write_data);
            end
        endcase

        result.border_colour = st.border_latch;
        result.ear_out = st.ear_latch;
        result.mic_out = st.mic_latch;
        result.screen_bank = st.screen_select;
        state_next = st;
    end

endmodule

// File: sv/spectrum128_paging_and_ula_ports_core.sv
`timescale 1ns / 1ps
// Top level: input register, decode, result register, paging and ULA latches.
// Depends on s128pg_pkg, s128pg_if and s128pg_decode.
//
// Takes one CPU bus access per transfer on req and returns one result per access on
// rsp. Throughput is one access per clock while rsp is not stalled; an accepted
// request passes through the input register, then the result register, to rsp.
// The paging and border latches are read and updated by the combinational decode
// logic between the two registers, so consecutive accesses see each other's effects
// with no gap. Configuration writes take effect at once and must be made while no
// access is in flight. No clearing pass is needed after reset.
module spectrum128_paging_and_ula_ports_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [0:0]          cfg_index,
    input  logic [0:0]          cfg_data,
    s128pg_req_if.sink          req,
    s128pg_rsp_if.source        rsp
);

    s128pg_pkg::req_item_t  s1_item_reg;
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    s128pg_pkg::rsp_item_t  out_item_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    s128pg_pkg::ula_state_t state_reg;
    s128pg_pkg::ula_state_t state_next;
    s128pg_pkg::cfg_t       cfg_reg;
    s128pg_pkg::rsp_item_t  result;
    logic                   advance;
    logic                   accept;

    s128pg_decode u_decode (
        .item       (s1_item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .result     (result),
        .state_next (state_next)
    );

    // result register empty or being drained this cycle
    assign advance = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || advance;
    assign accept = req.valid && req.ready;

    assign s1_valid_next = accept || (s1_valid_reg && !advance);
    assign out_valid_next = advance ? s1_valid_reg : out_valid_reg;

    assign rsp.valid = out_valid_reg;
    assign rsp.payload = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg <= '0;
            cfg_reg.has_paging <= 1'b1;
            cfg_reg.has_sound_chip <= 1'b1;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance && s1_valid_reg)
                state_reg <= state_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    s128pg_pkg::CFG_HAS_PAGING:     cfg_reg.has_paging <= cfg_data[0];
                    s128pg_pkg::CFG_HAS_SOUND_CHIP: cfg_reg.has_sound_chip <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= req.payload;
        if (advance && s1_valid_reg)
            out_item_reg <= result;
    end

endmodule

// File: sv/s128pg_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the paging and ULA port decoder, bound to the top level.
// Depends on s128pg_pkg and spectrum128_paging_and_ula_ports_core.
module s128pg_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input s128pg_pkg::rsp_item_t rsp_payload
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
        else $error("result changed while stalled");

    // request side backs up only behind a stalled result
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("request stalled with result side free");

    // a result appearing on an empty output came from a transfer that went straight through both registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result without matching request");

    // write strobe only into RAM; sound byte only for select or data write
    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!rsp_payload.mem_write || rsp_payload.mem_target == s128pg_pkg::TGT_RAM)
                   && (rsp_payload.sound_byte == 8'h00
                       || rsp_payload.sound_action == s128pg_pkg::SND_SELECT
                       || rsp_payload.sound_action == s128pg_pkg::SND_WRITE))
        else $error("inconsistent result fields");

endmodule

bind spectrum128_paging_and_ula_ports_core s128pg_checker u_s128pg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);

// File: tb/tb_spectrum128_paging_and_ula_ports_core.sv
`timescale 1ns / 1ps
// Testbench for the 128K paging and ULA port decoder: directed and random bus accesses,
// each result checked field by field against an in-bench decode model.
// Depends on s128pg_pkg, s128pg_if and spectrum128_paging_and_ula_ports_core.
module tb_spectrum128_paging_and_ula_ports_core;
    import s128pg_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int MAX_PRINTS  = 40;

    class access_decode_board;
        ula_state_t st;
        cfg_t       cfg;
        rsp_item_t  pending_decodes[$];
        int         errors;

        function new();
            st = '0;
            cfg.has_paging = 1'b1;
            cfg.has_sound_chip = 1'b1;
            errors = 0;
        endfunction

        function void set_reg(logic [0:0] idx, logic v);
            if (idx == CFG_HAS_PAGING)
                cfg.has_paging = v;
            else
                cfg.has_sound_chip = v;
        endfunction

        function bit page_busy(logic [1:0] page);
            return page == PAGE_RAM5 || (page == PAGE_PAGED && st.ram_bank[0]);
        endfunction

        function void load_paging(logic [7:0] v);
            if (v[5])
                st.paging_locked = 1'b1;
            st.rom_bank = v[4];
            st.ram_bank = v[2:0];
            st.screen_select = v[3];
        endfunction

        task report(string what, logic [39:0] got, logic [39:0] want);
            if (errors < MAX_PRINTS)
                $display("MISMATCH %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        // Work out the result of one accepted access and update the latches.
        function void note_access(req_item_t it);
            rsp_item_t   e;
            logic [1:0]  page;
            logic [13:0] offs;
            logic [2:0]  bank;
            logic [7:0]  r;
            logic [15:0] a;
            e = '0;
            a = it.address;
            page = a[15:14];
            offs = a[13:0];
            if (it.req_type == REQ_MEM_READ || it.req_type == REQ_MEM_WRITE)
            begin
                e.mem_target = TGT_RAM;
                case (page)
                    PAGE_ROM:
                    begin
                        e.mem_target = TGT_ROM;
                        bank = {2'b00, st.rom_bank};
                    end
                    PAGE_RAM5: bank = BANK_FIVE;
                    PAGE_RAM2: bank = BANK_TWO;
                    default:   bank = st.ram_bank;
                endcase
                e.contended = page_busy(page);
                if (it.req_type == REQ_MEM_WRITE)
                begin
                    if (e.mem_target == TGT_ROM)
                    begin
                        e.mem_target = TGT_NONE;
                        bank = '0;
                        offs = '0;
                    end
                    else
                        e.mem_write = 1'b1;
                end
                e.mem_address = {bank, offs};
            end
            else
            begin
                e.contended = cfg.has_paging && page_busy(page);
                if (it.req_type == REQ_IO_READ)
                begin
                    if (a[0])
                    begin
                        if (a[7:0] == JOYSTICK_PORT)
                            e.io_read_data = '0;
                        else if ((a & AY_MASK) == AY_SELECT_PORT && cfg.has_sound_chip)
                        begin
                            e.io_read_data = it.sound_read_data;
                            e.sound_action = SND_READ;
                        end
                        else
                        begin
                            // paging port read takes the floating bus, lock or not
                            if ((a & PAGING_MASK) == 16'h0000)
                                load_paging(it.floating_bus);
                            e.io_read_data = it.floating_bus;
                        end
                    end
                    else
                    begin
                        r = 8'hFF;
                        if (a[7:1] != 7'd0)
                        begin
                            for (int i = 0; i < KBD_ROWS; i++)
                                if (!a[8+i])
                                    r &= {3'b111, it.keyboard_rows[KBD_COLS*i +: KBD_COLS]};
                        end
                        e.io_read_data = (r & KBD_KEEP_MASK) |
                                         {1'b0, st.ear_latch | it.tape_bit, 6'b000000};
                    end
                end
                else
                begin
                    if (!a[0])
                    begin
                        st.ear_latch = it.write_data[4];
                        st.mic_latch = it.write_data[3];
                        st.border_latch = it.write_data[2:0];
                    end
                    if ((a & AY_MASK) == AY_SELECT_PORT && cfg.has_sound_chip)
                    begin
                        e.sound_action = SND_SELECT;
                        e.sound_byte = it.write_data;
                    end
                    if ((a & AY_MASK) == AY_DATA_PORT && cfg.has_sound_chip)
                    begin
                        e.sound_action = SND_WRITE;
                        e.sound_byte = it.write_data;
                    end
                    if ((a & PAGING_MASK) == 16'h0000 && !st.paging_locked)
                        load_paging(it.write_data);
                end
            end
            e.border_colour = st.border_latch;
            e.ear_out = st.ear_latch;
            e.mic_out = st.mic_latch;
            e.screen_bank = st.screen_select;
            pending_decodes.push_back(e);
        endfunction

        task check_decode(rsp_item_t got);
            rsp_item_t e;
            if (pending_decodes.size() == 0)
            begin
                report("unexpected result", 40'(got), 40'd0);
                return;
            end
            e = pending_decodes.pop_front();
            if (got.mem_target !== e.mem_target)
                report("mem_target", 40'(got.mem_target), 40'(e.mem_target));
            if (got.mem_address !== e.mem_address)
                report("mem_address", 40'(got.mem_address), 40'(e.mem_address));
            if (got.mem_write !== e.mem_write)
                report("mem_write", 40'(got.mem_write), 40'(e.mem_write));
            if (got.contended !== e.contended)
                report("contended", 40'(got.contended), 40'(e.contended));
            if (got.io_read_data !== e.io_read_data)
                report("io_read_data", 40'(got.io_read_data), 40'(e.io_read_data));
            if (got.border_colour !== e.border_colour)
                report("border_colour", 40'(got.border_colour), 40'(e.border_colour));
            if (got.ear_out !== e.ear_out)
                report("ear_out", 40'(got.ear_out), 40'(e.ear_out));
            if (got.mic_out !== e.mic_out)
                report("mic_out", 40'(got.mic_out), 40'(e.mic_out));
            if (got.screen_bank !== e.screen_bank)
                report("screen_bank", 40'(got.screen_bank), 40'(e.screen_bank));
            if (got.sound_action !== e.sound_action)
                report("sound_action", 40'(got.sound_action), 40'(e.sound_action));
            if (got.sound_byte !== e.sound_byte)
                report("sound_byte", 40'(got.sound_byte), 40'(e.sound_byte));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write_en;
    logic [0:0] cfg_index;
    logic [0:0] cfg_data;
    int         rx_cycle;
    int         quiet;

    s128pg_req_if req_ch();
    s128pg_rsp_if rsp_ch();

    access_decode_board board = new();

    spectrum128_paging_and_ula_ports_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req          (req_ch),
        .rsp          (rsp_ch)
    );

    always #1 clk = ~clk;

    function automatic logic [39:0] rand_rows();
        logic [63:0] w;
        w = {$urandom, $urandom};
        if ($urandom_range(0, 2) == 0)
        begin
            // mostly released keys with one or two pressed
            w = '1;
            w[$urandom_range(0, 39)] = 1'b0;
            w[$urandom_range(0, 39)] = 1'b0;
        end
        return w[39:0];
    endfunction

    function automatic req_item_t mk(req_type_t t, logic [15:0] a, logic [7:0] wd,
                                     logic [7:0] fb, logic [7:0] sr, logic tape);
        req_item_t it;
        it.req_type = t;
        it.address = a;
        it.write_data = wd;
        it.floating_bus = fb;
        it.sound_read_data = sr;
        it.keyboard_rows = rand_rows();
        it.tape_bit = tape;
        return it;
    endfunction

    function automatic req_item_t rand_access(bit allow_lock);
        req_item_t   it;
        logic [15:0] a;
        a = 16'($urandom);
        it = mk(REQ_MEM_READ, a, 8'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom_range(0, 1)));
        if ($urandom_range(0, 99) < 35)
            it.req_type = $urandom_range(0, 1) ? REQ_MEM_WRITE : REQ_MEM_READ;
        else
        begin
            it.req_type = $urandom_range(0, 1) ? REQ_IO_WRITE : REQ_IO_READ;
            case ($urandom_range(0, 6))
                0:
                begin
                    a = a & ~PAGING_MASK;
                    if ($urandom_range(0, 3) != 0)
                        a[0] = 1'b1;
                end
                1: a = (a & ~AY_MASK) | AY_SELECT_PORT;
                2: a = (a & ~AY_MASK) | AY_DATA_PORT;
                3:
                begin
                    a[0] = 1'b0;
                    if ($urandom_range(0, 3) == 0)
                        a[7:0] = 8'h00;
                    else if ($urandom_range(0, 1) == 0)
                        a[7:0] = 8'hFE;
                end
                4: a[7:0] = JOYSTICK_PORT;
                default: ;
            endcase
            it.address = a;
        end
        if (!allow_lock)
        begin
            it.write_data[5] = 1'b0;
            it.floating_bus[5] = 1'b0;
        end
        return it;
    endfunction

    // Hold valid until the transfer, then hand the access to the model.
    task automatic drive_access(req_item_t it);
        req_ch.valid <= 1'b1;
        req_ch.payload <= it;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.note_access(it);
    endtask

    task automatic idle_gap();
        if ($urandom_range(0, 3) != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic run_random(int n, bit allow_lock);
        int sent;
        int burst;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < n; k++)
            begin
                drive_access(rand_access(allow_lock));
                sent++;
            end
            idle_gap();
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (board.pending_decodes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic v);
        drain();
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        board.set_reg(idx, v);
    endtask

    // Result side: check every transfer, stall on a pattern that steps through four ready modes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rx_cycle <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                board.check_decode(rsp_ch.payload);
            rx_cycle <= rx_cycle + 1;
            case ((rx_cycle / 256) % 4)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                2: rsp_ch.ready <= ((rx_cycle % 7) < 4);
                default: rsp_ch.ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet = 0;
        else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("spectrum128_paging_and_ula_ports_core test failed");
                $finish;
            end
        end
    end

    initial
    begin
        req_ch.valid <= 1'b0;
        req_ch.payload <= '0;
        cfg_write_en <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: page edges, dropped ROM write, paged bank, ports
        drive_access(mk(REQ_MEM_READ, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0));
        drive_access(mk(REQ_MEM_WRITE, 16'h3FFF, 8'hFF, 8'h00, 8'h00, 1'b0));
        drive_access(mk(REQ_MEM_READ, 16'h4000, 8'h00, 8'h00, 8'h00, 1'b0));
        drive_access(mk(REQ_MEM_WRITE, 16'h7FFF, 8'h5A, 8'h00, 8'h00, 1'b0));
        drive_access(mk(REQ_MEM_READ, 16'h8000, 8'h00, 8'h00, 8'h00, 1'b0));
        drive_access(mk(REQ_MEM_WRITE, 16'hBFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        drive_access(mk(REQ_IO_WRITE, 16'h7FFD, 8'h17, 8'h00, 8'h00, 1'b0));
        drive_access(mk(REQ_MEM_READ, 16'hC000, 8'h00, 8'h00, 8'h00, 1'b0));
        drive_access(mk(REQ_MEM_WRITE, 16'hFFFF, 8'hA5, 8'h00, 8'h00, 1'b0));
        drive_access(mk(REQ_MEM_READ, 16'h0001, 8'h00, 8'h00, 8'h00, 1'b0));
        drive_access(mk(REQ_IO_READ, 16'h40FF, 8'h00, 8'hC3, 8'h00, 1'b0));
        drive_access(mk(REQ_IO_WRITE, 16'h00FE, 8'h1F, 8'h00, 8'h00, 1'b0));
        drive_access(mk(REQ_IO_READ, 16'h00FE, 8'h00, 8'h00, 8'h00, 1'b0));
        drive_access(mk(REQ_IO_WRITE, 16'h00FE, 8'h00, 8'h00, 8'h00, 1'b0));
        drive_access(mk(REQ_IO_READ, 16'hFEFE, 8'h00, 8'h00, 8'h00, 1'b1));
        drive_access(mk(REQ_IO_READ, 16'hFF00, 8'h00, 8'h00, 8'h00, 1'b0));
        drive_access(mk(REQ_IO_READ, 16'h001F, 8'h00, 8'hFF, 8'hFF, 1'b1));
        drive_access(mk(REQ_IO_WRITE, 16'hFFFD, 8'h0E, 8'h00, 8'h00, 1'b0));
        drive_access(mk(REQ_IO_WRITE, 16'hBFFD, 8'hA5, 8'h00, 8'h00, 1'b0));
        drive_access(mk(REQ_IO_READ, 16'hFFFD, 8'h00, 8'h00, 8'h5A, 1'b0));
        drive_access(mk(REQ_IO_READ, 16'h7FFD, 8'h00, 8'h08, 8'h00, 1'b0));
        // writes that each hit port FE together with the paging port or an AY port
        drive_access(mk(REQ_IO_WRITE, 16'h7FFC, 8'h0B, 8'h00, 8'h00, 1'b0));
        drive_access(mk(REQ_IO_WRITE, 16'hC000, 8'h15, 8'h00, 8'h00, 1'b0));
        drive_access(mk(REQ_IO_WRITE, 16'h8000, 8'hC7, 8'h00, 8'h00, 1'b0));
        idle_gap();
        run_random(250, 1'b0);

        write_reg(CFG_HAS_PAGING, 1'b0);
        write_reg(CFG_HAS_SOUND_CHIP, 1'b0);
        run_random(250, 1'b0);

        write_reg(CFG_HAS_PAGING, 1'b1);
        run_random(250, 1'b0);

        write_reg(CFG_HAS_PAGING, 1'b0);
        write_reg(CFG_HAS_SOUND_CHIP, 1'b1);
        run_random(250, 1'b0);

        write_reg(CFG_HAS_PAGING, 1'b1);
        run_random(150, 1'b0);
        // lock paging, then show writes ignored and the read path still loading
        drive_access(mk(REQ_IO_WRITE, 16'h7FFD, 8'h3F, 8'h00, 8'h00, 1'b0));
        drive_access(mk(REQ_IO_WRITE, 16'h7FFD, 8'h00, 8'h00, 8'h00, 1'b0));
        drive_access(mk(REQ_MEM_READ, 16'hC000, 8'h00, 8'h00, 8'h00, 1'b0));
        drive_access(mk(REQ_IO_READ, 16'h7FFD, 8'h00, 8'h02, 8'h00, 1'b0));
        drive_access(mk(REQ_MEM_READ, 16'hC123, 8'h00, 8'h00, 8'h00, 1'b0));
        drive_access(mk(REQ_MEM_READ, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0));
        run_random(100, 1'b1);

        drain();
        if (board.pending_decodes.size() != 0)
            board.report("results never arrived", 40'(board.pending_decodes.size()), 40'd0);
        if (board.errors == 0)
            $display("spectrum128_paging_and_ula_ports_core test passed");
        else
            $display("spectrum128_paging_and_ula_ports_core test failed");
        $finish;
    end
endmodule
